// ===== design/lzo_pkg.sv =====
package lzo_pkg;

   // pool size and field widths
   localparam int NUM_LAYERS = 16;
   localparam int ID_W       = 4;
   localparam int HGT_W      = 5;
   localparam int HREQ_W     = 6;
   localparam int IDX_W      = HGT_W + 1;

   // height of a hidden layer
   localparam logic signed [HGT_W-1:0] HGT_HIDDEN = '1;

   // request codes
   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_SET   = 2'd1,
      REQ_FREE  = 2'd2
   } req_code_type;

   // write ports into the layer store
   typedef struct packed {
      logic                    ord_we;
      logic [ID_W-1:0]         ord_addr;
      logic [ID_W-1:0]         ord_data;
      logic                    hgt_we;
      logic [ID_W-1:0]         hgt_addr;
      logic signed [HGT_W-1:0] hgt_data;
      logic                    use_we;
      logic [ID_W-1:0]         use_addr;
      logic                    use_data;
      logic                    top_we;
      logic signed [HGT_W-1:0] top_data;
   } lzo_wr_type;

   // read data out of the layer store
   typedef struct packed {
      logic                    use_sel;
      logic [ID_W-1:0]         ord_sel;
      logic signed [HGT_W-1:0] hgt_id;
      logic signed [HGT_W-1:0] top;
   } lzo_rd_type;

   // one step of the index walker
   typedef struct packed {
      logic                    done;
      logic signed [IDX_W-1:0] next;
      logic signed [IDX_W-1:0] dst;
   } lzo_walk_type;

endpackage

// ===== design/lzo_walk.sv =====
module lzo_walk (
   input  logic signed [lzo_pkg::IDX_W-1:0] idx,
   input  logic signed [lzo_pkg::IDX_W-1:0] last,
   input  logic                             up,
   output lzo_pkg::lzo_walk_type            step
);
   import lzo_pkg::*;

   // stop once the index runs past the last entry, else advance one place
   always_comb begin
      if (up) begin
         step.done = (idx > last);
         step.next = idx + IDX_W'(1);
         step.dst  = idx - IDX_W'(1);
      end else begin
         step.done = (idx < last);
         step.next = idx - IDX_W'(1);
         step.dst  = idx + IDX_W'(1);
      end
   end

endmodule

// ===== design/lzo_store.sv =====
module lzo_store (
   input  logic                       clock,
   input  logic                       reset,
   input  lzo_pkg::lzo_wr_type        wr,
   input  logic [lzo_pkg::ID_W-1:0]   sel_idx,
   input  logic [lzo_pkg::ID_W-1:0]   id,
   output lzo_pkg::lzo_rd_type        rd
);
   import lzo_pkg::*;

   logic                    use_ff   [NUM_LAYERS];
   logic signed [HGT_W-1:0] hgt_ff   [NUM_LAYERS];
   logic [ID_W-1:0]         order_ff [NUM_LAYERS];
   logic signed [HGT_W-1:0] top_ff;

   // slot flags, heights and top level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LAYERS; k++) begin
            use_ff[k] <= 1'b0;
            hgt_ff[k] <= HGT_HIDDEN;
         end
         top_ff <= HGT_HIDDEN;
      end else begin
         if (wr.use_we) begin
            use_ff[wr.use_addr] <= wr.use_data;
         end
         if (wr.hgt_we) begin
            hgt_ff[wr.hgt_addr] <= wr.hgt_data;
         end
         if (wr.top_we) begin
            top_ff <= wr.top_data;
         end
      end
   end

   // order list holds only entries that were written
   always_ff @(posedge clock) begin
      if (wr.ord_we) begin
         order_ff[wr.ord_addr] <= wr.ord_data;
      end
   end

   assign rd.use_sel = use_ff[sel_idx];
   assign rd.ord_sel = order_ff[sel_idx];
   assign rd.hgt_id  = hgt_ff[id];
   assign rd.top     = top_ff;

endmodule

// ===== design/lzo_ctrl.sv =====
module lzo_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [lzo_pkg::ID_W-1:0]          req_sheet_id,
   input  logic signed [lzo_pkg::HREQ_W-1:0] req_height_request,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [lzo_pkg::ID_W-1:0]          rsp_granted_id,
   output logic signed [lzo_pkg::HGT_W-1:0]  rsp_applied_height,
   output logic signed [lzo_pkg::HGT_W-1:0]  rsp_top_level,
   output logic                              rsp_redraw,
   input  lzo_pkg::lzo_rd_type               rd,
   output lzo_pkg::lzo_wr_type               wr,
   output logic [lzo_pkg::ID_W-1:0]          sel_idx,
   output logic [lzo_pkg::ID_W-1:0]          id,
   output logic signed [lzo_pkg::IDX_W-1:0]  walk_idx,
   output logic signed [lzo_pkg::IDX_W-1:0]  walk_last,
   output logic                              walk_up,
   input  lzo_pkg::lzo_walk_type             step
);
   import lzo_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_SHIFT,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SHIFT,
      KIND_REMOVE,
      KIND_INSERT
   } kind_type;

   state_type               state_ff, state_in;
   kind_type                kind_ff, kind_in;
   logic [1:0]              op_ff, op_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [ID_W-1:0]         gid_ff, gid_in;
   logic signed [HREQ_W-1:0] hreq_ff, hreq_in;
   logic signed [IDX_W-1:0] i_ff, i_in;
   logic signed [IDX_W-1:0] last_ff, last_in;
   logic                    up_ff, up_in;
   logic signed [HGT_W-1:0] h_ff, h_in;
   logic                    ok_ff, ok_in;
   logic                    rel_ff, rel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]         rsp_gid_ff, rsp_gid_in;
   logic signed [HGT_W-1:0] rsp_hgt_ff, rsp_hgt_in;
   logic signed [HGT_W-1:0] rsp_top_ff, rsp_top_in;
   logic                    rsp_redraw_ff, rsp_redraw_in;

   logic                    id_ok;
   logic signed [IDX_W-1:0] old_x, top_x, tgt_x;
   logic signed [IDX_W:0]   hreq_w, lim_w, clamp_w;
   logic signed [HGT_W-1:0] clamp, tgt, top_new;
   kind_type                plan_kind;
   logic                    plan_up;
   logic signed [IDX_W-1:0] plan_i, plan_last;
   logic                    fin_go;

   // clamp the requested height to the allowed range
   always_comb begin
      old_x  = {rd.hgt_id[HGT_W-1], rd.hgt_id};
      top_x  = {rd.top[HGT_W-1], rd.top};
      hreq_w = {hreq_ff[HREQ_W-1], hreq_ff};
      lim_w  = {top_x[IDX_W-1], top_x};
      if (rd.hgt_id < 0) begin
         lim_w = lim_w + (IDX_W+1)'(1);
      end
      clamp_w = (hreq_w > lim_w) ? lim_w : hreq_w;
      if (clamp_w < -1) begin
         clamp_w = '1;
      end
      clamp = clamp_w[HGT_W-1:0];
      tgt   = (op_ff == REQ_FREE) ? HGT_HIDDEN : clamp;
      tgt_x = {tgt[HGT_W-1], tgt};
   end

   // choose the walk that opens a place or closes a gap in the order list
   always_comb begin
      if (tgt < rd.hgt_id) begin
         if (tgt < 0) begin
            plan_kind = KIND_REMOVE;
            plan_up   = 1'b1;
            plan_i    = old_x + IDX_W'(1);
            plan_last = top_x;
         end else begin
            plan_kind = KIND_SHIFT;
            plan_up   = 1'b0;
            plan_i    = old_x - IDX_W'(1);
            plan_last = tgt_x;
         end
      end else if (rd.hgt_id < 0) begin
         plan_kind = KIND_INSERT;
         plan_up   = 1'b0;
         plan_i    = top_x;
         plan_last = tgt_x;
      end else begin
         plan_kind = KIND_SHIFT;
         plan_up   = 1'b1;
         plan_i    = old_x + IDX_W'(1);
         plan_last = tgt_x;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_REMOVE: top_new = rd.top - HGT_W'(1);
         KIND_INSERT: top_new = rd.top + HGT_W'(1);
         default:     top_new = rd.top;
      endcase
   end

   assign id_ok  = ({1'b0, id_ff} < (ID_W+1)'(NUM_LAYERS));
   assign fin_go = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      gid_in        = gid_ff;
      hreq_in       = hreq_ff;
      i_in          = i_ff;
      last_in       = last_ff;
      up_in         = up_ff;
      h_in          = h_ff;
      ok_in         = ok_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_gid_in    = rsp_gid_ff;
      rsp_hgt_in    = rsp_hgt_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_redraw_in = rsp_redraw_ff;
      wr            = '0;
      sel_idx       = id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               id_in    = req_sheet_id;
               gid_in   = req_sheet_id;
               hreq_in  = req_height_request;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            kind_in  = KIND_NONE;
            rel_in   = 1'b0;
            ok_in    = 1'b0;
            h_in     = id_ok ? rd.hgt_id : HGT_HIDDEN;
            state_in = ST_FIN;
            case (op_ff)
               REQ_ALLOC: begin
                  i_in     = '0;
                  up_in    = 1'b1;
                  last_in  = IDX_W'(NUM_LAYERS - 1);
                  state_in = ST_SCAN;
               end
               REQ_SET: begin
                  if (id_ok && rd.use_sel) begin
                     ok_in = 1'b1;
                     if (tgt != rd.hgt_id) begin
                        h_in     = tgt;
                        kind_in  = plan_kind;
                        up_in    = plan_up;
                        i_in     = plan_i;
                        last_in  = plan_last;
                        state_in = ST_SHIFT;
                     end
                  end
               end
               REQ_FREE: begin
                  if (id_ok) begin
                     ok_in  = 1'b1;
                     rel_in = 1'b1;
                     if (rd.hgt_id >= 0) begin
                        h_in     = HGT_HIDDEN;
                        kind_in  = plan_kind;
                        up_in    = plan_up;
                        i_in     = plan_i;
                        last_in  = plan_last;
                        state_in = ST_SHIFT;
                     end
                  end
               end
               default: ;
            endcase
         end

         // look for the lowest free slot, one slot per cycle
         ST_SCAN: begin
            sel_idx = i_ff[ID_W-1:0];
            if (step.done) begin
               ok_in    = 1'b0;
               gid_in   = '0;
               h_in     = HGT_HIDDEN;
               state_in = ST_FIN;
            end else if (!rd.use_sel) begin
               wr.use_we   = 1'b1;
               wr.use_addr = i_ff[ID_W-1:0];
               wr.use_data = 1'b1;
               wr.hgt_we   = 1'b1;
               wr.hgt_addr = i_ff[ID_W-1:0];
               wr.hgt_data = HGT_HIDDEN;
               ok_in       = 1'b1;
               gid_in      = i_ff[ID_W-1:0];
               h_in        = HGT_HIDDEN;
               state_in    = ST_FIN;
            end else begin
               i_in = step.next;
            end
         end

         // move one order entry per cycle and renumber its layer
         ST_SHIFT: begin
            sel_idx = i_ff[ID_W-1:0];
            if (step.done) begin
               state_in = ST_FIN;
            end else begin
               wr.ord_we   = 1'b1;
               wr.ord_addr = step.dst[ID_W-1:0];
               wr.ord_data = rd.ord_sel;
               wr.hgt_we   = 1'b1;
               wr.hgt_addr = rd.ord_sel;
               wr.hgt_data = step.dst[HGT_W-1:0];
               i_in        = step.next;
            end
         end

         // place the layer, settle top and release the slot with the result
         ST_FIN: begin
            if (fin_go) begin
               if (kind_ff != KIND_NONE) begin
                  wr.hgt_we   = 1'b1;
                  wr.hgt_addr = id_ff;
                  wr.hgt_data = h_ff;
                  wr.top_we   = 1'b1;
                  wr.top_data = top_new;
                  if (h_ff >= 0) begin
                     wr.ord_we   = 1'b1;
                     wr.ord_addr = h_ff[ID_W-1:0];
                     wr.ord_data = id_ff;
                  end
               end
               if (rel_ff) begin
                  wr.use_we   = 1'b1;
                  wr.use_addr = id_ff;
                  wr.use_data = 1'b0;
               end
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = ok_ff;
               rsp_gid_in    = gid_ff;
               rsp_hgt_in    = h_ff;
               rsp_top_in    = top_new;
               rsp_redraw_in = (kind_ff != KIND_NONE);
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      gid_ff        <= gid_in;
      hreq_ff       <= hreq_in;
      i_ff          <= i_in;
      last_ff       <= last_in;
      up_ff         <= up_in;
      h_ff          <= h_in;
      ok_ff         <= ok_in;
      rel_ff        <= rel_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_gid_ff    <= rsp_gid_in;
      rsp_hgt_ff    <= rsp_hgt_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_redraw_ff <= rsp_redraw_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_granted_id     = rsp_gid_ff;
   assign rsp_applied_height = rsp_hgt_ff;
   assign rsp_top_level      = rsp_top_ff;
   assign rsp_redraw         = rsp_redraw_ff;
   assign id                 = id_ff;
   assign walk_idx           = i_ff;
   assign walk_last          = last_ff;
   assign walk_up            = up_ff;

endmodule

// ===== design/layer_z_order_table.sv =====
// Layer manager with 16 layer slots and a bottom-to-top order list of the
// visible layers. One request is handled at a time; req_ready is high only
// while the block is idle, and the result sits in an output register so the
// next request is taken while it waits. Allocate scans the slots from the
// lowest upward; a set-height or free that moves the layer also shifts the
// layers that lie between its old and new place in the order list. The
// single index walker visits one slot or one order entry per cycle. A result
// still waiting for rsp_ready holds the next result back for as long as it
// waits. No clearing pass is needed after reset.
module layer_z_order_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [lzo_pkg::ID_W-1:0]          req_sheet_id,
   input  logic signed [lzo_pkg::HREQ_W-1:0] req_height_request,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [lzo_pkg::ID_W-1:0]          rsp_granted_id,
   output logic signed [lzo_pkg::HGT_W-1:0]  rsp_applied_height,
   output logic signed [lzo_pkg::HGT_W-1:0]  rsp_top_level,
   output logic                              rsp_redraw
);
   import lzo_pkg::*;

   lzo_wr_type              wr;
   lzo_rd_type              rd;
   lzo_walk_type            step;
   logic [ID_W-1:0]         sel_idx;
   logic [ID_W-1:0]         id;
   logic signed [IDX_W-1:0] walk_idx;
   logic signed [IDX_W-1:0] walk_last;
   logic                    walk_up;

   lzo_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_sheet_id       (req_sheet_id),
      .req_height_request (req_height_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_granted_id     (rsp_granted_id),
      .rsp_applied_height (rsp_applied_height),
      .rsp_top_level      (rsp_top_level),
      .rsp_redraw         (rsp_redraw),
      .rd                 (rd),
      .wr                 (wr),
      .sel_idx            (sel_idx),
      .id                 (id),
      .walk_idx           (walk_idx),
      .walk_last          (walk_last),
      .walk_up            (walk_up),
      .step               (step)
   );

   lzo_walk u_walk (
      .idx  (walk_idx),
      .last (walk_last),
      .up   (walk_up),
      .step (step)
   );

   lzo_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .sel_idx (sel_idx),
      .id      (id),
      .rd      (rd)
   );

endmodule

// ===== design/lzo_check.sv =====
module lzo_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_type,
   input logic [lzo_pkg::ID_W-1:0]          req_sheet_id,
   input logic signed [lzo_pkg::HREQ_W-1:0] req_height_request,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_ok,
   input logic [lzo_pkg::ID_W-1:0]          rsp_granted_id,
   input logic signed [lzo_pkg::HGT_W-1:0]  rsp_applied_height,
   input logic signed [lzo_pkg::HGT_W-1:0]  rsp_top_level,
   input logic                              rsp_redraw
);
   import lzo_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_granted_id)
         && $stable(rsp_applied_height) && $stable(rsp_top_level) && $stable(rsp_redraw))
      else $error("stalled result changed");

   // drop ready after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // a redraw comes only with a successful request
   a_redraw_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_redraw |-> rsp_ok)
      else $error("redraw on failed request");

   // a visible layer never sits above the top level
   a_under_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok && (rsp_applied_height >= 0) |-> rsp_applied_height <= rsp_top_level)
      else $error("layer above top level");

endmodule

bind layer_z_order_table lzo_check u_check (.*);
